[hw/rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bencode structure scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_END   = 8'h65;
    localparam logic [7:0] CH_DICT  = 8'h64;
    localparam logic [7:0] CH_LIST  = 8'h6C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int LEN_RADIX   = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_DICT = 2'd0;
    localparam logic [1:0] KIND_LIST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LEN_FAULT = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef enum logic [1:0] {
        MODE_TOP  = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_BODY = 2'd2,
        MODE_INT  = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        EVT_NONE      = 3'd0,
        EVT_OPEN_D    = 3'd1,
        EVT_OPEN_L    = 3'd2,
        EVT_CLOSE     = 3'd3,
        EVT_LEN_FAULT = 3'd4
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t kind;
        logic      clear;
    } scan_evt_t;

endpackage

[hw/rtl/bss_if.sv]
// ----------------------------------------------------------------------------
// bss_if
// Word channels of the scanner: input bytes and marker results.
// ----------------------------------------------------------------------------
interface bss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;

    modport source
    (
        output valid,
        output byte_value,
        output first_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  byte_value,
        input  first_byte,
        output ready
    );
endinterface

interface bss_marker_if #(parameter int POSITION_BITS = 24);
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] marker_position;
    logic [1:0]               marker_kind;
    logic [5:0]               nesting_depth;
    logic [1:0]               status;

    modport source
    (
        output valid,
        output marker_position,
        output marker_kind,
        output nesting_depth,
        output status,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  marker_position,
        input  marker_kind,
        input  nesting_depth,
        input  status,
        output ready
    );
endinterface

[hw/rtl/bss_front.sv]
// ----------------------------------------------------------------------------
// bss_front
// Byte scanner: tracks scan mode, string length and skip count, and queues
// one event per marker, length fault or buffer start.
// ----------------------------------------------------------------------------
module bss_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    bss_byte_if.sink                                        in_ch,
    input  logic                                            push_ready,
    output logic                                            push_valid,
    output logic [POSITION_BITS+$bits(bss_pkg::scan_evt_t)-1:0] push_data
);

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    bss_pkg::scan_mode_t mode_reg, mode_next, mode_cur;
    logic [PB-1:0]       accum_reg, accum_next, accum_cur;
    logic [PB-1:0]       skip_reg, skip_next, skip_cur, skip_dec;
    logic [PB-1:0]       pos_reg, pos_next, pos_cur;
    logic                accept;
    logic                is_digit;
    logic [3:0]          digit;
    logic [PB+3:0]       accum_x10;
    logic [PB-1:0]       accum_sat;
    bss_pkg::scan_evt_t  evt;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid & in_ch.ready;

    assign mode_cur  = in_ch.first_byte ? bss_pkg::MODE_TOP : mode_reg;
    assign accum_cur = in_ch.first_byte ? '0 : accum_reg;
    assign skip_cur  = in_ch.first_byte ? '0 : skip_reg;
    assign pos_cur   = in_ch.first_byte ? '0 : pos_reg;

    assign is_digit = (in_ch.byte_value >= bss_pkg::CH_ZERO)
                    && (in_ch.byte_value <= bss_pkg::CH_NINE);
    assign digit    = 4'(in_ch.byte_value - bss_pkg::CH_ZERO);

    assign accum_x10 = ({4'b0, accum_cur} << 3) + ({4'b0, accum_cur} << 1)
                     + {{PB{1'b0}}, digit};
    assign accum_sat = (accum_x10[PB+3:PB] != 4'b0) ? POS_MAX : accum_x10[PB-1:0];
    assign skip_dec  = (skip_cur != '0) ? skip_cur - 1'b1 : skip_cur;

    // next state
    always_comb
    begin
        mode_next  = mode_cur;
        accum_next = accum_cur;
        skip_next  = skip_cur;
        pos_next   = pos_cur + 1'b1;
        unique case (mode_cur)
            bss_pkg::MODE_TOP:
            begin
                if (is_digit)
                begin
                    accum_next = {{(PB-4){1'b0}}, digit};
                    mode_next  = bss_pkg::MODE_LEN;
                end
                else if (in_ch.byte_value == bss_pkg::CH_INT)
                begin
                    mode_next = bss_pkg::MODE_INT;
                end
            end
            bss_pkg::MODE_LEN:
            begin
                if (is_digit)
                begin
                    accum_next = accum_sat;
                end
                else if (in_ch.byte_value == bss_pkg::CH_COLON)
                begin
                    accum_next = '0;
                    if (accum_cur == '0)
                    begin
                        mode_next = bss_pkg::MODE_TOP;
                    end
                    else
                    begin
                        skip_next = accum_cur;
                        mode_next = bss_pkg::MODE_BODY;
                    end
                end
                else
                begin
                    accum_next = '0;
                    mode_next  = bss_pkg::MODE_TOP;
                end
            end
            bss_pkg::MODE_BODY:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    mode_next = bss_pkg::MODE_TOP;
                end
            end
            bss_pkg::MODE_INT:
            begin
                if (in_ch.byte_value == bss_pkg::CH_END)
                begin
                    mode_next = bss_pkg::MODE_TOP;
                end
            end
            default:
            begin
                mode_next = bss_pkg::MODE_TOP;
            end
        endcase
    end

    // event classification
    always_comb
    begin
        evt.clear = in_ch.first_byte;
        evt.kind  = bss_pkg::EVT_NONE;
        unique case (mode_cur)
            bss_pkg::MODE_TOP:
            begin
                if (in_ch.byte_value == bss_pkg::CH_DICT)
                begin
                    evt.kind = bss_pkg::EVT_OPEN_D;
                end
                else if (in_ch.byte_value == bss_pkg::CH_LIST)
                begin
                    evt.kind = bss_pkg::EVT_OPEN_L;
                end
                else if (in_ch.byte_value == bss_pkg::CH_END)
                begin
                    evt.kind = bss_pkg::EVT_CLOSE;
                end
            end
            bss_pkg::MODE_LEN:
            begin
                if (!is_digit && (in_ch.byte_value != bss_pkg::CH_COLON))
                begin
                    evt.kind = bss_pkg::EVT_LEN_FAULT;
                end
            end
            default:
            begin
                evt.kind = bss_pkg::EVT_NONE;
            end
        endcase
    end

    assign push_valid = accept && ((evt.kind != bss_pkg::EVT_NONE) || evt.clear);
    assign push_data  = {evt, pos_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bss_pkg::MODE_TOP;
            accum_reg <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

[hw/rtl/bss_queue.sv]
// ----------------------------------------------------------------------------
// bss_queue
// Short event queue between the scanner and the depth tracker.
// ----------------------------------------------------------------------------
module bss_queue #(
    parameter int WIDTH = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (bss_pkg::QUEUE_DEPTH > 1) ? $clog2(bss_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(bss_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(bss_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(bss_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0]    entry_reg [bss_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/bss_back.sv]
// ----------------------------------------------------------------------------
// bss_back
// Depth tracker: applies queued events to the nesting depth and registers
// one marker result per event that carries a marker or a length fault.
// ----------------------------------------------------------------------------
module bss_back #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_DEPTH     = 32
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            pop_valid,
    output logic                                            pop_ready,
    input  logic [POSITION_BITS+$bits(bss_pkg::scan_evt_t)-1:0] pop_data,
    bss_marker_if.source                                    out_ch
);

    localparam int PB = POSITION_BITS;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    bss_pkg::scan_evt_t evt;
    logic [PB-1:0]      evt_pos;
    logic [DW-1:0]      depth_reg, depth_next, depth_cur;
    logic               do_pop;
    logic               has_result;
    logic [1:0]         res_kind;
    logic [1:0]         res_status;
    logic [DW-1:0]      res_depth;
    logic [DW+5:0]      res_depth_wide;

    logic               out_valid_reg, out_valid_next;
    logic [PB-1:0]      out_pos_reg;
    logic [1:0]         out_kind_reg;
    logic [5:0]         out_depth_reg;
    logic [1:0]         out_status_reg;

    assign evt       = bss_pkg::scan_evt_t'(pop_data[PB +: $bits(bss_pkg::scan_evt_t)]);
    assign evt_pos   = pop_data[PB-1:0];
    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign do_pop    = pop_valid & pop_ready;
    assign depth_cur = evt.clear ? '0 : depth_reg;

    always_comb
    begin
        has_result = 1'b1;
        res_kind   = bss_pkg::KIND_DICT;
        res_status = bss_pkg::ST_OK;
        res_depth  = depth_cur;
        depth_next = depth_cur;
        unique case (evt.kind)
            bss_pkg::EVT_OPEN_D,
            bss_pkg::EVT_OPEN_L:
            begin
                res_kind = (evt.kind == bss_pkg::EVT_OPEN_D) ? bss_pkg::KIND_DICT
                                                             : bss_pkg::KIND_LIST;
                if (depth_cur >= DEPTH_MAX)
                begin
                    res_status = bss_pkg::ST_OVERFLOW;
                end
                else
                begin
                    depth_next = depth_cur + 1'b1;
                    res_depth  = depth_cur + 1'b1;
                end
            end
            bss_pkg::EVT_CLOSE:
            begin
                res_kind = bss_pkg::KIND_END;
                if (depth_cur == '0)
                begin
                    res_status = bss_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    depth_next = depth_cur - 1'b1;
                end
            end
            bss_pkg::EVT_LEN_FAULT:
            begin
                res_status = bss_pkg::ST_LEN_FAULT;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    assign res_depth_wide = {6'b0, res_depth};

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (do_pop)
        begin
            out_valid_next = has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                depth_reg <= depth_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && has_result)
        begin
            out_pos_reg    <= evt_pos;
            out_kind_reg   <= res_kind;
            out_depth_reg  <= res_depth_wide[5:0];
            out_status_reg <= res_status;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.marker_position = out_pos_reg;
    assign out_ch.marker_kind     = out_kind_reg;
    assign out_ch.nesting_depth   = out_depth_reg;
    assign out_ch.status          = out_status_reg;

endmodule

[hw/rtl/bencode_structure_scanner.sv]
// Throughput: one byte per cycle, sustained, with the output taken each cycle.
// A marker byte accepted by the scanner is written into the event queue and then
//   into the depth tracker's output register, which drives the output.
// The two-entry event queue lets the byte scanner run on while a result stalls.
// Reset: rst_n clears mode, counters, position, depth and all valid flags at
//   once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bencode_structure_scanner
// Scans a bencoded byte stream and reports each container open and close
// with its position and nesting depth, flagging malformed structure.
// ----------------------------------------------------------------------------
module bencode_structure_scanner #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_DEPTH     = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    bss_byte_if.sink     in_ch,
    bss_marker_if.source out_ch
);

    localparam int QW = POSITION_BITS + $bits(bss_pkg::scan_evt_t);

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    bss_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    bss_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bss_back #(
        .POSITION_BITS (POSITION_BITS),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule
